// ----- hdl/dlps_pkg.sv -----
package dlps_pkg;

   localparam int SPECULAR_POWER_LOG2 = 5;

   localparam int ROOT_W      = 16;
   localparam int SQ_STEPS    = 2;
   localparam int SQ_STAGES   = ROOT_W / SQ_STEPS;
   localparam int QUO_W       = 16;
   localparam int DIV_STEPS   = 2;
   localparam int DIV_STAGES  = QUO_W / DIV_STEPS;
   localparam int UNIT_LAT    = SQ_STAGES + DIV_STAGES + 1;

   localparam logic [14:0] ONE_Q14 = 15'd16384;
   localparam logic [23:0] OUT_MAX = 24'hFFFFFF;

   typedef enum logic [2:0] {
      REG_LIGHT_DIR_X     = 3'd0,
      REG_LIGHT_DIR_Y     = 3'd1,
      REG_LIGHT_DIR_Z     = 3'd2,
      REG_LIGHT_RED       = 3'd3,
      REG_LIGHT_GREEN     = 3'd4,
      REG_LIGHT_BLUE      = 3'd5,
      REG_LIGHT_INTENSITY = 3'd6
   } csr_idx_type;

   localparam logic [15:0] RST_LIGHT_DIR_X     = 16'h0000;
   localparam logic [15:0] RST_LIGHT_DIR_Y     = 16'hFF00;
   localparam logic [15:0] RST_LIGHT_DIR_Z     = 16'h0000;
   localparam logic [7:0]  RST_LIGHT_COLOR     = 8'd255;
   localparam logic [15:0] RST_LIGHT_INTENSITY = 16'd256;

   typedef logic [2:0][15:0] vec_type;

   typedef struct packed {
      logic [31:0]       rem;
      logic [ROOT_W-1:0] root;
   } sq_type;

   typedef struct packed {
      logic [31:0]      rem;
      logic [QUO_W-1:0] quo;
   } dv_type;

   typedef struct packed {
      logic [31:0] level;
      logic [15:0] shine;
      logic        shadowed;
   } side_type;

   typedef struct packed {
      logic [15:0]       shine;
      logic              shadowed;
      logic [47:0]       li;
      logic [2:0][33:0]  draw;
      logic [2:0][23:0]  dsat;
   } tail_type;

   function automatic logic [30:0] sq16(logic [15:0] x);
      logic signed [31:0] p;
      p = $signed(x) * $signed(x);
      return p[30:0];
   endfunction

   function automatic sq_type sqrt_step(sq_type s, int i);
      sq_type     r;
      logic [33:0] t;
      r = s;
      t = (34'(s.root) << (i + 1)) + (34'd1 << (2 * i));
      if (34'(s.rem) >= t) begin
         r.rem  = s.rem - t[31:0];
         r.root = s.root | (ROOT_W'(1) << i);
      end
      return r;
   endfunction

   function automatic dv_type div_step(dv_type d, logic [15:0] len, int i);
      dv_type     r;
      logic [31:0] t;
      r = d;
      t = 32'(len) << i;
      if (d.rem >= t) begin
         r.rem = d.rem - t;
         r.quo = d.quo | (QUO_W'(1) << i);
      end
      return r;
   endfunction

endpackage

// ----- hdl/dlps_unitize.sv -----
module dlps_unitize (
   input  logic             clock,
   input  logic             adv,
   input  dlps_pkg::vec_type a,
   input  logic [31:0]      ss,
   output dlps_pkg::vec_type u
);

   dlps_pkg::sq_type  sq_ff [dlps_pkg::SQ_STAGES];
   dlps_pkg::vec_type sa_ff [dlps_pkg::SQ_STAGES];

   dlps_pkg::dv_type  dv_ff  [dlps_pkg::DIV_STAGES][3];
   logic [15:0]       len_ff [dlps_pkg::DIV_STAGES];
   logic [2:0]        neg_ff [dlps_pkg::DIV_STAGES];

   dlps_pkg::vec_type u_ff;

   for (genvar g = 0; g < dlps_pkg::SQ_STAGES; g++) begin : g_sq
      dlps_pkg::sq_type  cur;
      dlps_pkg::sq_type  nxt;
      dlps_pkg::vec_type cur_a;
      if (g == 0) begin : g_first
         assign cur   = '{rem: ss, root: '0};
         assign cur_a = a;
      end else begin : g_rest
         assign cur   = sq_ff[g-1];
         assign cur_a = sa_ff[g-1];
      end
      always_comb begin
         nxt = cur;
         for (int j = 0; j < dlps_pkg::SQ_STEPS; j++) begin
            nxt = dlps_pkg::sqrt_step(nxt, dlps_pkg::ROOT_W - 1 - (g * dlps_pkg::SQ_STEPS + j));
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            sq_ff[g] <= nxt;
            sa_ff[g] <= cur_a;
         end
      end
   end

   for (genvar g = 0; g < dlps_pkg::DIV_STAGES; g++) begin : g_dv
      dlps_pkg::dv_type cur [3];
      dlps_pkg::dv_type nxt [3];
      logic [15:0]      cur_len;
      logic [2:0]       cur_neg;
      if (g == 0) begin : g_first
         dlps_pkg::vec_type la;
         logic [16:0]       mag [3];
         assign la      = sa_ff[dlps_pkg::SQ_STAGES-1];
         assign cur_len = sq_ff[dlps_pkg::SQ_STAGES-1].root;
         for (genvar i = 0; i < 3; i++) begin : g_in
            assign mag[i]     = la[i][15] ? (17'd0 - {1'b1, la[i]}) : {1'b0, la[i]};
            assign cur[i]     = '{rem: {1'b0, mag[i], 14'd0}, quo: '0};
            assign cur_neg[i] = la[i][15];
         end
      end else begin : g_rest
         assign cur     = dv_ff[g-1];
         assign cur_len = len_ff[g-1];
         assign cur_neg = neg_ff[g-1];
      end
      always_comb begin
         for (int i = 0; i < 3; i++) begin
            nxt[i] = cur[i];
            for (int j = 0; j < dlps_pkg::DIV_STEPS; j++) begin
               nxt[i] = dlps_pkg::div_step(nxt[i], cur_len,
                                           dlps_pkg::QUO_W - 1 - (g * dlps_pkg::DIV_STEPS + j));
            end
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            dv_ff[g]  <= nxt;
            len_ff[g] <= cur_len;
            neg_ff[g] <= cur_neg;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            if (len_ff[dlps_pkg::DIV_STAGES-1] == 16'd0) begin
               u_ff[i] <= '0;
            end else if (neg_ff[dlps_pkg::DIV_STAGES-1][i]) begin
               u_ff[i] <= 16'd0 - dv_ff[dlps_pkg::DIV_STAGES-1][i].quo;
            end else begin
               u_ff[i] <= dv_ff[dlps_pkg::DIV_STAGES-1][i].quo;
            end
         end
      end
   end

   assign u = u_ff;

endmodule

// ----- hdl/directional_light_phong_shade_top.sv -----
// Channel   Ports                       Content
// req       req_tvalid/tready/tdata/tuser  one hit point per beat
// rsp       rsp_tvalid/tready/tdata     three channel additions per beat
// csr       csr_we/index/wdata          light registers, write only
//
// One beat per cycle in and out while rsp is not stalled; a req beat passes
// 34 register stages before it shows on rsp, 17 of them in the normalize unit's
// 8-stage square root, 8-stage divide and output register.
// Reset is synchronous, clears the valid bits and loads the light registers' reset values.
// A stalled rsp beat freezes the whole pipeline; nothing is dropped.
module directional_light_phong_shade_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // normal_x, normal_y, normal_z, view_x, view_y, view_z, shine_level
   input  logic [111:0] req_tdata,
   // shadowed
   input  logic [0:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // red_add, green_add, blue_add
   output logic [71:0]  rsp_tdata,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [15:0]  csr_wdata
);

   localparam int UL  = dlps_pkg::UNIT_LAT;
   localparam int P   = dlps_pkg::SPECULAR_POWER_LOG2;
   localparam int U   = 2 + UL;
   localparam int NT  = 8 + P;
   localparam int LAT = U + 10 + P;

   dlps_pkg::vec_type ldir_ff;
   logic [2:0][7:0]   color_ff;
   logic [15:0]       inten_ff;

   logic             adv;
   logic [LAT-1:0]   vld_ff;

   dlps_pkg::vec_type n0_ff, v0_ff, n1_ff, v1_ff, n2_ff, v2_ff;
   logic [15:0]       sh0_ff, sh1_ff, sh2_ff;
   logic              shd0_ff, shd1_ff, shd2_ff;
   logic signed [31:0] nlp_ff [3];
   logic [30:0]       sqn_ff [3];
   logic [30:0]       sqv_ff [3];
   logic [30:0]       sql_ff [3];
   logic [31:0]       lev_ff, ssn_ff, ssv_ff, ssl_ff;
   logic signed [33:0] nsum;
   dlps_pkg::side_type dly_ff [UL];
   dlps_pkg::vec_type  nu, vu, lu;

   logic signed [31:0] dp_ff [3];
   dlps_pkg::vec_type  e1_nu_ff, e1_lu_ff, e1_vu_ff, e2_nu_ff, e2_lu_ff, e2_vu_ff;
   dlps_pkg::vec_type  e3_lu_ff, e3_vu_ff, e4_vu_ff;
   logic signed [31:0] d_ff;
   logic signed [47:0] rp_ff [3];
   logic signed [19:0] r_ff [3];
   logic signed [35:0] rv_ff [3];
   logic [14:0]        pw_ff [P+1];
   logic [30:0]        sa_ff;
   logic [24:0]        spec_ff;
   logic [71:0]        out_ff;

   dlps_pkg::tail_type tail_ff [NT];
   dlps_pkg::tail_type tail_in [NT];

   logic signed [33:0] dsum;
   logic signed [47:0] mprod [3];
   logic signed [47:0] rbias [3];
   logic signed [37:0] xsum;
   logic [14:0]        s_in;
   logic [14:0]        pw_in [P+1];
   logic [46:0]        sprod;
   logic [2:0][23:0]   out_in;

   assign adv        = !vld_ff[LAT-1] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[LAT-1];
   assign rsp_tdata  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ldir_ff[0]  <= dlps_pkg::RST_LIGHT_DIR_X;
         ldir_ff[1]  <= dlps_pkg::RST_LIGHT_DIR_Y;
         ldir_ff[2]  <= dlps_pkg::RST_LIGHT_DIR_Z;
         color_ff[0] <= dlps_pkg::RST_LIGHT_COLOR;
         color_ff[1] <= dlps_pkg::RST_LIGHT_COLOR;
         color_ff[2] <= dlps_pkg::RST_LIGHT_COLOR;
         inten_ff    <= dlps_pkg::RST_LIGHT_INTENSITY;
      end else if (csr_we) begin
         case (csr_index)
            dlps_pkg::REG_LIGHT_DIR_X:     ldir_ff[0]  <= csr_wdata;
            dlps_pkg::REG_LIGHT_DIR_Y:     ldir_ff[1]  <= csr_wdata;
            dlps_pkg::REG_LIGHT_DIR_Z:     ldir_ff[2]  <= csr_wdata;
            dlps_pkg::REG_LIGHT_RED:       color_ff[0] <= csr_wdata[7:0];
            dlps_pkg::REG_LIGHT_GREEN:     color_ff[1] <= csr_wdata[7:0];
            dlps_pkg::REG_LIGHT_BLUE:      color_ff[2] <= csr_wdata[7:0];
            dlps_pkg::REG_LIGHT_INTENSITY: inten_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAT-2:0], req_tvalid};
      end
   end

   // front: capture, products, sums
   always_comb begin
      nsum = 34'(nlp_ff[0]) + 34'(nlp_ff[1]) + 34'(nlp_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         n0_ff   <= req_tdata[47:0];
         v0_ff   <= req_tdata[95:48];
         sh0_ff  <= req_tdata[111:96];
         shd0_ff <= req_tuser[0];
         for (int i = 0; i < 3; i++) begin
            nlp_ff[i] <= $signed(n0_ff[i]) * $signed(ldir_ff[i]);
            sqn_ff[i] <= dlps_pkg::sq16(n0_ff[i]);
            sqv_ff[i] <= dlps_pkg::sq16(v0_ff[i]);
            sql_ff[i] <= dlps_pkg::sq16(ldir_ff[i]);
         end
         n1_ff   <= n0_ff;
         v1_ff   <= v0_ff;
         sh1_ff  <= sh0_ff;
         shd1_ff <= shd0_ff;
         lev_ff  <= (nsum > 34'sd0) ? 32'd0 : 32'(34'sd0 - nsum);
         ssn_ff  <= 32'(sqn_ff[0]) + 32'(sqn_ff[1]) + 32'(sqn_ff[2]);
         ssv_ff  <= 32'(sqv_ff[0]) + 32'(sqv_ff[1]) + 32'(sqv_ff[2]);
         ssl_ff  <= 32'(sql_ff[0]) + 32'(sql_ff[1]) + 32'(sql_ff[2]);
         n2_ff   <= n1_ff;
         v2_ff   <= v1_ff;
         sh2_ff  <= sh1_ff;
         shd2_ff <= shd1_ff;
         dly_ff[0] <= '{level: lev_ff, shine: sh2_ff, shadowed: shd2_ff};
         for (int k = 1; k < UL; k++) begin
            dly_ff[k] <= dly_ff[k-1];
         end
      end
   end

   dlps_unitize u_unit_n (.clock(clock), .adv(adv), .a(n2_ff),   .ss(ssn_ff), .u(nu));
   dlps_unitize u_unit_v (.clock(clock), .adv(adv), .a(v2_ff),   .ss(ssv_ff), .u(vu));
   dlps_unitize u_unit_l (.clock(clock), .adv(adv), .a(ldir_ff), .ss(ssl_ff), .u(lu));

   // diffuse and pass-through fields
   always_comb begin
      logic [55:0] cp;
      tail_in[0]          = '0;
      tail_in[0].shine    = dly_ff[UL-1].shine;
      tail_in[0].shadowed = dly_ff[UL-1].shadowed;
      tail_in[0].li       = 48'(dly_ff[UL-1].level) * 48'(inten_ff);
      for (int k = 1; k < NT; k++) begin
         tail_in[k] = tail_ff[k-1];
      end
      for (int c = 0; c < 3; c++) begin
         cp                 = 56'(tail_ff[0].li) * 56'(color_ff[c]);
         tail_in[1].draw[c] = cp[55:22];
         tail_in[2].dsat[c] = (tail_ff[1].draw[c] > 34'(dlps_pkg::OUT_MAX)) ?
                              dlps_pkg::OUT_MAX : tail_ff[1].draw[c][23:0];
      end
   end

   // specular, then the output sum with saturation and shadowing
   always_comb begin
      dsum = 34'(dp_ff[0]) + 34'(dp_ff[1]) + 34'(dp_ff[2]);
      for (int i = 0; i < 3; i++) begin
         mprod[i] = 48'(d_ff) * 48'($signed(e2_nu_ff[i]));
         rbias[i] = rp_ff[i] + (rp_ff[i][47] ? 48'sd268435455 : 48'sd0);
      end
      xsum = 38'sd0 - (38'(rv_ff[0]) + 38'(rv_ff[1]) + 38'(rv_ff[2]));
      if (xsum <= 38'sd0) begin
         s_in = '0;
      end else if (xsum[37:14] > 24'(dlps_pkg::ONE_Q14)) begin
         s_in = dlps_pkg::ONE_Q14;
      end else begin
         s_in = xsum[28:14];
      end
      pw_in[0] = s_in;
      for (int k = 1; k <= P; k++) begin
         pw_in[k] = 15'((30'(pw_ff[k-1]) * 30'(pw_ff[k-1])) >> 14);
      end
      sprod = 47'(sa_ff) * 47'(tail_ff[6+P].shine);
      for (int c = 0; c < 3; c++) begin
         logic [25:0] tot;
         tot = 26'(tail_ff[7+P].dsat[c]) + 26'(spec_ff);
         if (tail_ff[7+P].shadowed) begin
            out_in[c] = '0;
         end else begin
            out_in[c] = (tot > 26'(dlps_pkg::OUT_MAX)) ? dlps_pkg::OUT_MAX : tot[23:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < NT; k++) begin
            tail_ff[k] <= tail_in[k];
         end
         for (int i = 0; i < 3; i++) begin
            dp_ff[i] <= 32'($signed(nu[i]) * $signed(lu[i]));
            rp_ff[i] <= {mprod[i][46:0], 1'b0};
            r_ff[i]  <= $signed(rbias[i][47:28]) + 20'($signed(e3_lu_ff[i]));
            rv_ff[i] <= 36'(r_ff[i]) * 36'($signed(e4_vu_ff[i]));
         end
         e1_nu_ff <= nu;
         e1_lu_ff <= lu;
         e1_vu_ff <= vu;
         d_ff     <= 32'(34'sd0 - dsum);
         e2_nu_ff <= e1_nu_ff;
         e2_lu_ff <= e1_lu_ff;
         e2_vu_ff <= e1_vu_ff;
         e3_lu_ff <= e2_lu_ff;
         e3_vu_ff <= e2_vu_ff;
         e4_vu_ff <= e3_vu_ff;
         for (int k = 0; k <= P; k++) begin
            pw_ff[k] <= pw_in[k];
         end
         sa_ff   <= 31'(inten_ff) * 31'(pw_ff[P]);
         spec_ff <= sprod[46:22];
         out_ff  <= {out_in[2], out_in[1], out_in[0]};
      end
   end

endmodule
